[design/hhfp_pkg.sv]
// Shared types, codes and helper functions of the HTTP header field parser.
package hhfp_pkg;

    localparam int unsigned DEFAULT_MAX_HEADERS = 64;
    localparam int unsigned HN_W = 7;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 3;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;

    typedef enum logic [KIND_W-1:0] {
        K_KEY_BYTE   = 3'd0,
        K_KEY_END    = 3'd1,
        K_VALUE_BYTE = 3'd2,
        K_HEADER_END = 3'd3,
        K_BLOCK_END  = 3'd4,
        K_MALFORMED  = 3'd5
    } t_kind;

    typedef enum logic [6:0] {
        PH_LINE     = 7'b0000001,
        PH_LINE_CR  = 7'b0000010,
        PH_KEY      = 7'b0000100,
        PH_SKIP     = 7'b0001000,
        PH_VALUE    = 7'b0010000,
        PH_VALUE_CR = 7'b0100000,
        PH_DONE     = 7'b1000000
    } t_phase;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] text;
        logic [HN_W-1:0]   hnum;
        logic              last;
    } t_result;

    typedef struct packed {
        t_phase phase;
        logic   emit;
        t_kind  kind;
    } t_step;

    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic t_result mk_result(t_kind kind, logic [BYTE_W-1:0] b,
                                          logic [HN_W-1:0] hn, logic last);
        t_result r;
        r.kind = kind;
        r.text = (kind == K_KEY_BYTE || kind == K_VALUE_BYTE) ? b : CH_NUL;
        r.hnum = hn;
        r.last = last;
        return r;
    endfunction

    function automatic t_step key_step(logic [BYTE_W-1:0] b);
        t_step s;
        s.emit = 1'b1;
        if (b == CH_NUL) begin
            s.phase = PH_DONE;
            s.kind  = K_MALFORMED;
        end else if (b == CH_COLON) begin
            s.phase = PH_SKIP;
            s.kind  = K_KEY_END;
        end else begin
            s.phase = PH_KEY;
            s.kind  = K_KEY_BYTE;
        end
        return s;
    endfunction

    function automatic t_step value_step(logic [BYTE_W-1:0] b);
        t_step s;
        if (b == CH_NUL || b == CH_LF) begin
            s.phase = PH_DONE;
            s.emit  = 1'b1;
            s.kind  = K_MALFORMED;
        end else if (b == CH_CR) begin
            s.phase = PH_VALUE_CR;
            s.emit  = 1'b0;
            s.kind  = K_MALFORMED;
        end else begin
            s.phase = PH_VALUE;
            s.emit  = 1'b1;
            s.kind  = K_VALUE_BYTE;
        end
        return s;
    endfunction

endpackage

[design/hhfp_parse.sv]
// Input register, parse state and result decode of the header field parser.
module hhfp_parse
    import hhfp_pkg::*;
#(
    parameter int unsigned MAX_HEADERS = DEFAULT_MAX_HEADERS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_start_of_message,
    input  logic              i_room,
    output t_push             o_push
);

    localparam int unsigned CNT_BITS = $clog2(MAX_HEADERS + 1);
    localparam int unsigned CNT_W = (CNT_BITS > HN_W) ? CNT_BITS : HN_W;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_som;
    t_phase            r_phase, n_phase;
    logic [CNT_W-1:0]  r_count, n_count;

    logic              fire;
    t_phase            ph;
    logic [CNT_W-1:0]  ce;
    logic [HN_W-1:0]   hn;
    t_step             ks, vs;
    t_push             push;

    assign fire    = r_in_valid && i_room;
    assign o_ready = !r_in_valid || i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_byte <= i_data_byte;
            r_som  <= i_start_of_message;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LINE;
            r_count <= '0;
        end else if (fire) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    assign ph = r_som ? PH_LINE : r_phase;
    assign ce = r_som ? '0 : r_count;
    assign hn = ce[HN_W-1:0];
    assign ks = key_step(r_byte);
    assign vs = value_step(r_byte);

    always_comb begin
        n_phase    = ph;
        n_count    = ce;
        push.count = 2'd0;
        push.r0    = mk_result(K_MALFORMED, CH_NUL, hn, 1'b1);
        push.r1    = mk_result(K_MALFORMED, CH_NUL, hn, 1'b1);
        unique case (ph)
            PH_LINE: begin
                if (r_byte == CH_CR) begin
                    n_phase = PH_LINE_CR;
                end else begin
                    n_phase    = ks.phase;
                    push.count = 2'd1;
                    push.r0    = mk_result(ks.kind, r_byte, hn, 1'b1);
                end
            end
            PH_LINE_CR: begin
                if (r_byte == CH_LF) begin
                    n_phase    = PH_DONE;
                    push.count = 2'd1;
                    push.r0    = mk_result(K_BLOCK_END, CH_NUL, hn, 1'b1);
                end else begin
                    n_phase    = ks.phase;
                    push.count = 2'd2;
                    push.r0    = mk_result(K_KEY_BYTE, CH_CR, hn, 1'b0);
                    push.r1    = mk_result(ks.kind, r_byte, hn, 1'b1);
                end
            end
            PH_KEY: begin
                n_phase    = ks.phase;
                push.count = 2'd1;
                push.r0    = mk_result(ks.kind, r_byte, hn, 1'b1);
            end
            PH_SKIP, PH_VALUE: begin
                if (ph == PH_VALUE || (r_byte != CH_SPACE && r_byte != CH_TAB)) begin
                    n_phase    = vs.phase;
                    push.count = {1'b0, vs.emit};
                    push.r0    = mk_result(vs.kind, r_byte, hn, 1'b1);
                end
            end
            PH_VALUE_CR: begin
                push.count = 2'd1;
                if (r_byte == CH_LF) begin
                    n_phase = PH_LINE;
                    push.r0 = mk_result(K_HEADER_END, CH_NUL, hn, 1'b1);
                    if (ce < CNT_W'(MAX_HEADERS)) begin
                        n_count = ce + CNT_W'(1);
                    end
                end else begin
                    n_phase = PH_DONE;
                    push.r0 = mk_result(K_MALFORMED, CH_NUL, hn, 1'b1);
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    always_comb begin
        o_push = push;
        if (!fire) begin
            o_push.count = 2'd0;
        end
    end

endmodule

[design/hhfp_result_fifo.sv]
// Four-entry result queue that takes up to two results per cycle.
module hhfp_result_fifo
    import hhfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             pop;
    logic [PTR_W-1:0] wr1;

    assign o_room   = (r_cnt <= CNT_W'(DEPTH - 2));
    assign o_valid  = (r_cnt != '0);
    assign o_result = r_mem[r_rd];
    assign pop      = o_valid && i_ready;
    assign wr1      = r_wr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PTR_W'(i_push.count);
            r_rd  <= r_rd + PTR_W'(pop);
            r_cnt <= r_cnt + CNT_W'(i_push.count) - CNT_W'(pop);
        end
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr1] <= i_push.r1;
        end
    end

endmodule

[design/http_header_field_parser.sv]
// Top level of the HTTP header field parser.
//
// Input channel: one header text byte per item on i_data_byte, with
// i_start_of_message high on the first byte of a new block. Output channel:
// one token per item (kind, byte, header index, last-of-byte flag). A byte
// yields zero, one or two tokens; two only when a CR at line start is not
// followed by LF.
// Path: a byte is captured in the input register, then decoded and written
// into the result queue, from which its token drives o_valid; a queue without
// room for two tokens holds the byte in the input register.
// Throughput: one byte per cycle while the receiver takes one token per
// cycle; the four-entry result queue absorbs a second token from a byte.
// Input stalls when the queue has fewer than two free entries.
// Reset (synchronous, active low) returns the parser to line start with a
// zero header count and empties the queue. Stalling the receiver holds the
// head token and, once the queue fills, holds o_ready low.
module http_header_field_parser
    import hhfp_pkg::*;
#(
    parameter int unsigned MAX_HEADERS = DEFAULT_MAX_HEADERS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_start_of_message,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [KIND_W-1:0] o_token_kind,
    output logic [BYTE_W-1:0] o_text_byte,
    output logic [HN_W-1:0]   o_header_number,
    output logic              o_last_of_run
);

    t_push   push;
    logic    room;
    t_result res;

    hhfp_parse #(
        .MAX_HEADERS(MAX_HEADERS)
    ) u_parse (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_data_byte       (i_data_byte),
        .i_start_of_message(i_start_of_message),
        .i_room            (room),
        .o_push            (push)
    );

    hhfp_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_result(res)
    );

    assign o_token_kind    = res.kind;
    assign o_text_byte     = res.text;
    assign o_header_number = res.hnum;
    assign o_last_of_run   = res.last;

endmodule

[design/hhfp_checker.sv]
// Port-level checker of the HTTP header field parser and its bind.
module hhfp_checker
    import hhfp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input logic [KIND_W-1:0] o_token_kind,
    input logic [BYTE_W-1:0] o_text_byte
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("token valid right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("token dropped while stalled");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_token_kind <= K_MALFORMED))
        else $error("token kind out of range");

    a_text_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind != K_KEY_BYTE && o_token_kind != K_VALUE_BYTE
        |-> o_text_byte == CH_NUL)
        else $error("text byte set on a marker token");

endmodule

bind http_header_field_parser hhfp_checker u_hhfp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_token_kind(o_token_kind),
    .o_text_byte (o_text_byte)
);
